@@ rtl/line_rasterizer_core_macros.svh @@
// Assertion macros shared by the line rasterizer RTL.
`ifndef LINE_RASTERIZER_CORE_MACROS_SVH
`define LINE_RASTERIZER_CORE_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define LRC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Checks that a consequence holds in the same cycle as its cause.
`define LRC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a consequence holds in the cycle after its cause.
`define LRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lr_pkg.sv @@
// Package with shared types and constants of the line rasterizer.
`default_nettype none

package lr_pkg;

    localparam int COORD_BITS_DEF = 12;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } t_cmd;

    typedef struct packed {
        logic x_backward;
        logic y_backward;
        logic x_is_major;
    } t_flags;

endpackage

`default_nettype wire

@@ rtl/lr_setup.sv @@
// Line setup: direction, major axis, deltas and initial decision term.
`default_nettype none

module lr_setup #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic [COORD_BITS-1:0]   i_x_start,
    input  wire logic [COORD_BITS-1:0]   i_y_start,
    input  wire logic [COORD_BITS-1:0]   i_x_end,
    input  wire logic [COORD_BITS-1:0]   i_y_end,
    output lr_pkg::t_flags               o_flags,
    output logic [COORD_BITS-1:0]        o_major,
    output logic [COORD_BITS-1:0]        o_minor,
    output logic signed [COORD_BITS+1:0] o_decision,
    output logic signed [COORD_BITS+1:0] o_inc_diag
);

    logic                  x_back;
    logic                  y_back;
    logic                  x_major;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;

    always_comb begin
        x_back  = i_x_end < i_x_start;
        y_back  = i_y_end < i_y_start;
        dx      = x_back ? (i_x_start - i_x_end) : (i_x_end - i_x_start);
        dy      = y_back ? (i_y_start - i_y_end) : (i_y_end - i_y_start);
        x_major = dx >= dy;

        o_flags.x_backward = x_back;
        o_flags.y_backward = y_back;
        o_flags.x_is_major = x_major;

        o_major = x_major ? dx : dy;
        o_minor = x_major ? dy : dx;

        o_decision = $signed({1'b0, o_minor, 1'b0}) - $signed({2'b00, o_major});
        o_inc_diag = $signed({1'b0, o_minor, 1'b0}) - $signed({1'b0, o_major, 1'b0});
    end

endmodule

`default_nettype wire

@@ rtl/line_rasterizer_core.sv @@
// Top level of the line rasterizer: stream ports, line state and pixel output register.
//
//  Channel  | Direction | tdata (low bit up)                     | Side band
//  s_axis   | in        | x_start, y_start, x_end, y_end         | tuser = cmd
//  m_axis   | out       | pixel_x, pixel_y                       | tlast = last
//
// A new word is accepted each cycle while the output register is empty or being
// drained. The line state and the output register are updated at the accepting
// edge, so a pixel appears in the cycle after its step word.
// A load word sets up the line and produces no output word.
// The reset is synchronous and active low; no line is loaded after reset.
// A stalled output holds its word and stops input acceptance until it is taken.
`default_nettype none

module line_rasterizer_core #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // x_start, y_start, x_end, y_end
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // cmd
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // pixel_x, pixel_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_axis_tdata,
    output logic                                     m_axis_tlast
);

    `include "line_rasterizer_core_macros.svh"

    localparam int DEC_BITS      = COORD_BITS + 2;
    localparam int OUT_DATA_BITS = ((2*COORD_BITS+7)/8)*8;

    logic [COORD_BITS-1:0]      x_start;
    logic [COORD_BITS-1:0]      y_start;
    logic [COORD_BITS-1:0]      x_end;
    logic [COORD_BITS-1:0]      y_end;
    lr_pkg::t_flags             setup_flags;
    logic [COORD_BITS-1:0]      setup_major;
    logic [COORD_BITS-1:0]      setup_minor;
    logic signed [DEC_BITS-1:0] setup_decision;
    logic signed [DEC_BITS-1:0] setup_inc_diag;

    logic                       accept;
    logic                       is_load;
    logic                       minor_step;
    logic [COORD_BITS-1:0]      x_moved;
    logic [COORD_BITS-1:0]      y_moved;

    logic [COORD_BITS-1:0]      r_cur_x,    n_cur_x;
    logic [COORD_BITS-1:0]      r_cur_y,    n_cur_y;
    logic signed [DEC_BITS-1:0] r_decision, n_decision;
    logic signed [DEC_BITS-1:0] r_inc_diag, n_inc_diag;
    logic [COORD_BITS-1:0]      r_steps,    n_steps;
    logic [COORD_BITS-1:0]      r_major,    n_major;
    logic [COORD_BITS-1:0]      r_minor,    n_minor;
    lr_pkg::t_flags             r_flags,    n_flags;
    logic                       r_active,   n_active;
    logic                       r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0]      r_pix_x,    n_pix_x;
    logic [COORD_BITS-1:0]      r_pix_y,    n_pix_y;
    logic                       r_out_last, n_out_last;

    assign x_start = s_axis_tdata[COORD_BITS-1:0];
    assign y_start = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign x_end   = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign y_end   = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

    lr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_x_start  (x_start),
        .i_y_start  (y_start),
        .i_x_end    (x_end),
        .i_y_end    (y_end),
        .o_flags    (setup_flags),
        .o_major    (setup_major),
        .o_minor    (setup_minor),
        .o_decision (setup_decision),
        .o_inc_diag (setup_inc_diag)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_load       = lr_pkg::t_cmd'(s_axis_tuser) == lr_pkg::CMD_LOAD;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_DATA_BITS'({r_pix_y, r_pix_x});

    always_comb begin
        minor_step = !r_decision[DEC_BITS-1];
        x_moved    = r_flags.x_backward ? (r_cur_x - 1'b1) : (r_cur_x + 1'b1);
        y_moved    = r_flags.y_backward ? (r_cur_y - 1'b1) : (r_cur_y + 1'b1);

        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_decision  = r_decision;
        n_inc_diag  = r_inc_diag;
        n_steps     = r_steps;
        n_major     = r_major;
        n_minor     = r_minor;
        n_flags     = r_flags;
        n_active    = r_active;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_pix_x     = r_pix_x;
        n_pix_y     = r_pix_y;
        n_out_last  = r_out_last;

        if (accept) begin
            if (is_load) begin
                n_cur_x    = x_start;
                n_cur_y    = y_start;
                n_decision = setup_decision;
                n_inc_diag = setup_inc_diag;
                n_steps    = setup_major;
                n_major    = setup_major;
                n_minor    = setup_minor;
                n_flags    = setup_flags;
                n_active   = 1'b1;
            end else if (r_active) begin
                n_out_valid = 1'b1;
                n_pix_x     = r_cur_x;
                n_pix_y     = r_cur_y;
                n_out_last  = r_steps == '0;
                if (r_steps == '0) begin
                    n_active = 1'b0;
                end else begin
                    if (r_flags.x_is_major || minor_step) begin
                        n_cur_x = x_moved;
                    end
                    if (!r_flags.x_is_major || minor_step) begin
                        n_cur_y = y_moved;
                    end
                    if (minor_step) begin
                        n_decision = r_decision + r_inc_diag;
                    end else begin
                        n_decision = r_decision + $signed({1'b0, r_minor, 1'b0});
                    end
                    n_steps = r_steps - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_decision  <= '0;
            r_inc_diag  <= '0;
            r_steps     <= '0;
            r_major     <= '0;
            r_minor     <= '0;
            r_flags     <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_decision  <= n_decision;
            r_inc_diag  <= n_inc_diag;
            r_steps     <= n_steps;
            r_major     <= n_major;
            r_minor     <= n_minor;
            r_flags     <= n_flags;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix_x <= n_pix_x;
        r_pix_y <= n_pix_y;
    end

    `LRC_ASSERT_ALWAYS(a_steps_in_range, i_clk, i_rst_n, r_steps <= r_major,
        "Remaining steps exceed the major delta.")
    `LRC_ASSERT_ALWAYS(a_minor_not_above_major, i_clk, i_rst_n, r_minor <= r_major,
        "Minor delta exceeds the major delta.")
    `LRC_ASSERT_SAME(a_last_ends_line, i_clk, i_rst_n, r_out_valid && r_out_last,
        !r_active, "A pending last pixel while the line is still active.")
    `LRC_ASSERT_NEXT(a_step_gives_pixel, i_clk, i_rst_n, accept && !is_load && r_active,
        r_out_valid, "An accepted step word on an active line gave no pixel.")
    `LRC_ASSERT_NEXT(a_load_starts_line, i_clk, i_rst_n, accept && is_load,
        r_active && !r_out_valid, "A load word did not start a line cleanly.")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking stream testbench for line_rasterizer_core with a Bresenham pixel predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int CW       = lr_pkg::COORD_BITS_DEF;
    localparam int IN_BITS  = ((4 * CW + 7) / 8) * 8;
    localparam int OUT_BITS = ((2 * CW + 7) / 8) * 8;
    localparam int MAX_C    = (1 << CW) - 1;

    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } t_pixel;

    class pixel_scoreboard;
        t_pixel        expected_pixels[$];
        int            errors;
        logic [CW-1:0] pos_x, pos_y, steps_to_go, d_major, d_minor;
        int            err_term;
        logic          x_down, y_down, x_major, line_live;

        function new();
            errors      = 0;
            pos_x       = '0;
            pos_y       = '0;
            steps_to_go = '0;
            d_major     = '0;
            d_minor     = '0;
            err_term    = 0;
            x_down      = 1'b0;
            y_down      = 1'b0;
            x_major     = 1'b0;
            line_live   = 1'b0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return expected_pixels.size();
        endfunction

        function void note_word(logic cmd, logic [CW-1:0] xs, logic [CW-1:0] ys,
                                logic [CW-1:0] xe, logic [CW-1:0] ye);
            logic [CW-1:0] dx, dy;
            t_pixel        px;
            logic          minor_step;
            if (cmd == lr_pkg::CMD_LOAD) begin
                x_down      = xe < xs;
                y_down      = ye < ys;
                dx          = x_down ? xs - xe : xe - xs;
                dy          = y_down ? ys - ye : ye - ys;
                x_major     = dx >= dy;
                d_major     = x_major ? dx : dy;
                d_minor     = x_major ? dy : dx;
                err_term    = 2 * int'(d_minor) - int'(d_major);
                steps_to_go = d_major;
                pos_x       = xs;
                pos_y       = ys;
                line_live   = 1'b1;
                return;
            end
            if (!line_live)
                return;
            px.x    = pos_x;
            px.y    = pos_y;
            px.last = steps_to_go == 0;
            expected_pixels.push_back(px);
            if (steps_to_go == 0) begin
                line_live = 1'b0;
                return;
            end
            minor_step = err_term >= 0;
            if (x_major || minor_step)
                pos_x = x_down ? pos_x - 1'b1 : pos_x + 1'b1;
            if (!x_major || minor_step)
                pos_y = y_down ? pos_y - 1'b1 : pos_y + 1'b1;
            if (minor_step)
                err_term += 2 * int'(d_minor) - 2 * int'(d_major);
            else
                err_term += 2 * int'(d_minor);
            steps_to_go = steps_to_go - 1'b1;
        endfunction

        task check_pixel(logic [OUT_BITS-1:0] data, logic last);
            t_pixel px;
            if (expected_pixels.size() == 0) begin
                report($sformatf("unexpected pixel word x=%0d y=%0d last=%0b",
                                 data[CW-1:0], data[2*CW-1:CW], last));
                return;
            end
            px = expected_pixels.pop_front();
            if (data[CW-1:0] !== px.x)
                report($sformatf("pixel_x %0d, expected %0d", data[CW-1:0], px.x));
            if (data[2*CW-1:CW] !== px.y)
                report($sformatf("pixel_y %0d, expected %0d", data[2*CW-1:CW], px.y));
            if (last !== px.last)
                report($sformatf("last %0b, expected %0b at (%0d,%0d)",
                                 last, px.last, px.x, px.y));
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata;   // x_start, y_start, x_end, y_end
    logic                s_axis_tuser;   // cmd
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_BITS-1:0] m_axis_tdata;   // pixel_x, pixel_y
    logic                m_axis_tlast;   // last

    pixel_scoreboard sb;
    bit              calm;
    int              items;

    line_rasterizer_core #(
        .COORD_BITS(CW)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic send_word(logic cmd, logic [CW-1:0] xs, logic [CW-1:0] ys,
                             logic [CW-1:0] xe, logic [CW-1:0] ye);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_BITS'({ye, xe, ys, xs});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic draw_line(logic [CW-1:0] xs, logic [CW-1:0] ys,
                             logic [CW-1:0] xe, logic [CW-1:0] ye, int n_steps);
        send_word(lr_pkg::CMD_LOAD, xs, ys, xe, ye);
        repeat (n_steps)
            send_word(lr_pkg::CMD_STEP, CW'($urandom), CW'($urandom),
                      CW'($urandom), CW'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
    endtask

    function automatic logic [CW-1:0] near_coord(logic [CW-1:0] c, int d);
        if ($urandom_range(0, 1) && int'(c) >= d)
            return c - CW'(d);
        else if (int'(c) + d <= MAX_C)
            return c + CW'(d);
        return c - CW'(d);
    endfunction

    task automatic random_line(output int counted);
        logic [CW-1:0] xs, ys, xe, ye;
        int            d, ax, ay, major, n_steps, shape;
        bit            huge;
        xs    = CW'($urandom);
        ys    = CW'($urandom);
        huge  = $urandom_range(0, 24) == 0;
        shape = $urandom_range(0, 7);
        d     = $urandom_range(0, 12);
        if (huge) begin
            xe = CW'($urandom);
            ye = CW'($urandom);
        end else if (shape == 0) begin
            xe = near_coord(xs, d);
            ye = ys;
        end else if (shape == 1) begin
            xe = xs;
            ye = near_coord(ys, d);
        end else if (shape == 2) begin
            xe = near_coord(xs, d);
            ye = near_coord(ys, d);
        end else begin
            xe = near_coord(xs, d);
            ye = near_coord(ys, $urandom_range(0, 12));
        end
        ax    = xe > xs ? int'(xe - xs) : int'(xs - xe);
        ay    = ye > ys ? int'(ye - ys) : int'(ys - ye);
        major = ax >= ay ? ax : ay;
        shape = $urandom_range(0, 9);
        if (huge)
            n_steps = $urandom_range(1, 40);
        else if (shape == 0)
            n_steps = $urandom_range(0, major);
        else if (shape == 1)
            n_steps = major + 1 + $urandom_range(1, 3);
        else
            n_steps = major + 1;
        counted = 1 + (n_steps < major + 1 ? n_steps : major + 1);
        draw_line(xs, ys, xe, ye, n_steps);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_word(s_axis_tuser, s_axis_tdata[CW-1:0], s_axis_tdata[2*CW-1:CW],
                         s_axis_tdata[3*CW-1:2*CW], s_axis_tdata[4*CW-1:3*CW]);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata, m_axis_tlast);
    end

    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        int  counted;
        bit  paused;
        sb            = new();
        calm          = 1'b0;
        items         = 0;
        paused        = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= lr_pkg::CMD_LOAD;
        s_axis_tdata  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(lr_pkg::CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0);
        draw_line(12'd5, 12'd5, 12'd5, 12'd5, 2);
        draw_line(12'd0, 12'd0, 12'd4095, 12'd4095, 3);
        draw_line(12'd4095, 12'd4095, 12'd4090, 12'd4095, 6);
        draw_line(12'd0, 12'd4093, 12'd0, 12'd4095, 3);
        draw_line(12'd4095, 12'd0, 12'd4094, 12'd3, 4);

        while (items < 950) begin
            calm = (items / 120) % 4 == 3;
            if (!paused && items >= 475) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 19) == 0) begin
                send_word(1'($urandom), CW'($urandom), CW'($urandom),
                          CW'($urandom), CW'($urandom));
                items++;
            end else begin
                random_line(counted);
                items += counted;
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lr_pkg.sv
rtl/lr_setup.sv
rtl/line_rasterizer_core.sv
dv/testbench.sv
